/* design/assert_macros.svh */
// Assertion macros shared by the comment stripper RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* design/ccs_pkg.sv */
// Types, character codes and the per-byte comment scan function of the comment stripper.
// Depends on nothing; used by ccs_core, ccs_burst_buf and c_comment_stripper.
`default_nettype none

package ccs_pkg;

	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;

	localparam logic [1:0] MODE_CODE   = 2'd0;
	localparam logic [1:0] MODE_STRING = 2'd1;
	localparam logic [1:0] MODE_LINE   = 2'd2;
	localparam logic [1:0] MODE_BLOCK  = 2'd3;

	localparam int MAX_RESULTS = 3;

	typedef struct packed {
		logic [1:0] mode;
		logic       held_slash;
		logic       star_seen;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{mode: MODE_CODE, held_slash: 1'b0, star_seen: 1'b0};

	typedef struct packed {
		scan_state_t st;
		logic [1:0]  n;
		logic [7:0]  c0;
		logic [7:0]  c1;
	} strip_res_t;

	typedef struct packed {
		logic [1:0]                  len;
		logic [MAX_RESULTS-1:0][7:0] ch;
	} burst_t;

	// One byte through the comment stage: next state and up to two output bytes.
	function automatic strip_res_t strip_fn(scan_state_t s, logic [7:0] x);
		strip_res_t r;
		r.st = s;
		r.n  = 2'd0;
		r.c0 = x;
		r.c1 = CH_SPACE;
		case (s.mode)
			MODE_CODE: begin
				if (s.held_slash) begin
					r.st.held_slash = 1'b0;
					if (x == CH_SLASH) begin
						r.st.mode = MODE_LINE;
						r.n  = 2'd2;
						r.c0 = CH_SPACE;
					end else if (x == CH_STAR) begin
						r.st.mode      = MODE_BLOCK;
						r.st.star_seen = 1'b0;
						r.n  = 2'd2;
						r.c0 = CH_SPACE;
					end else begin
						if (x == CH_QUOTE)
							r.st.mode = MODE_STRING;
						r.n  = 2'd2;
						r.c0 = CH_SLASH;
						r.c1 = x;
					end
				end else if (x == CH_SLASH) begin
					r.st.held_slash = 1'b1;
				end else begin
					if (x == CH_QUOTE)
						r.st.mode = MODE_STRING;
					r.n = 2'd1;
				end
			end
			MODE_STRING: begin
				if (x == CH_QUOTE || x == CH_NEWLINE)
					r.st.mode = MODE_CODE;
				r.n = 2'd1;
			end
			MODE_LINE: begin
				if (x == CH_NEWLINE)
					r.st.mode = MODE_CODE;
				else
					r.c0 = CH_SPACE;
				r.n = 2'd1;
			end
			default: begin
				if (s.star_seen && x == CH_SLASH) begin
					r.st.mode      = MODE_CODE;
					r.st.star_seen = 1'b0;
					r.c0 = CH_SPACE;
				end else begin
					r.st.star_seen = (x == CH_STAR);
					r.c0 = (x == CH_NEWLINE) ? CH_NEWLINE : CH_SPACE;
				end
				r.n = 2'd1;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/ccs_core.sv */
// Input register, splice and scan state, and the per-item step that forms a result burst.
// Depends on ccs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ccs_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      text_char,
	input  wire logic            end_of_text,
	input  wire logic            load_ok,
	output logic                 burst_load,
	output ccs_pkg::burst_t      burst
);

	logic                 vld_s1;
	logic [7:0]           char_s1;
	logic                 eot_s1;
	ccs_pkg::scan_state_t st_q, nxt_st;
	logic                 hb_q, nxt_hb;
	ccs_pkg::strip_res_t  r1, r2;
	ccs_pkg::scan_state_t src2, eot_st;
	logic [1:0]           n1, n2;
	logic [7:0]           a0, a1, b0, b1;
	logic [7:0]           e [4];
	logic [2:0]           total;

	assign burst_load = vld_s1 && load_ok;
	assign in_ready   = !vld_s1 || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= text_char;
			eot_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ccs_pkg::SCAN_RESET;
			hb_q <= 1'b0;
		end else if (burst_load) begin
			st_q <= nxt_st;
			hb_q <= nxt_hb;
		end
	end

	always_comb begin
		r1     = ccs_pkg::strip_fn(st_q, ccs_pkg::CH_BACKSLASH);
		src2   = hb_q ? r1.st : st_q;
		r2     = ccs_pkg::strip_fn(src2, char_s1);
		eot_st = hb_q ? r1.st : st_q;
		nxt_st = st_q;
		nxt_hb = hb_q;
		n1 = 2'd0;
		n2 = 2'd0;
		a0 = r1.c0;
		a1 = r1.c1;
		b0 = r2.c0;
		b1 = r2.c1;
		if (eot_s1) begin
			if (hb_q)
				n1 = r1.n;
			if (eot_st.held_slash) begin
				n2 = 2'd1;
				b0 = ccs_pkg::CH_SLASH;
			end
			nxt_st = ccs_pkg::SCAN_RESET;
			nxt_hb = 1'b0;
		end else if (hb_q) begin
			if (char_s1 == ccs_pkg::CH_NEWLINE) begin
				nxt_hb = 1'b0;
			end else begin
				n1 = r1.n;
				if (char_s1 == ccs_pkg::CH_BACKSLASH) begin
					nxt_st = r1.st;
					nxt_hb = 1'b1;
				end else begin
					n2     = r2.n;
					nxt_st = r2.st;
					nxt_hb = 1'b0;
				end
			end
		end else if (char_s1 == ccs_pkg::CH_BACKSLASH) begin
			nxt_hb = 1'b1;
		end else begin
			n2     = r2.n;
			nxt_st = r2.st;
		end
	end

	always_comb begin
		e[0] = a0;
		e[1] = a1;
		e[2] = ccs_pkg::CH_SPACE;
		e[3] = ccs_pkg::CH_SPACE;
		if (n2 != 2'd0)
			e[n1] = b0;
		if (n2 == 2'd2)
			e[n1 + 2'd1] = b1;
		total     = {1'b0, n1} + {1'b0, n2};
		burst.len = (total > 3'd3) ? 2'd3 : total[1:0];
		burst.ch  = {e[2], e[1], e[0]};
	end

	`ASSERT_AT(a_eot_resets, clk, arst_n,
		(burst_load && eot_s1) |=> (st_q == ccs_pkg::SCAN_RESET && !hb_q),
		"end of text did not reset scan state")
	`ASSERT_NEVER(a_slash_only_code, clk, arst_n,
		st_q.held_slash && st_q.mode != ccs_pkg::MODE_CODE,
		"held slash outside code mode")
	`ASSERT_NEVER(a_star_only_block, clk, arst_n,
		st_q.star_seen && st_q.mode != ccs_pkg::MODE_BLOCK,
		"star flag outside block comment")

endmodule

`default_nettype wire

/* design/ccs_burst_buf.sv */
// Result register holding one burst of up to three bytes, drained one item per cycle while out_ready is high.
// Depends on ccs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ccs_burst_buf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            burst_load,
	input  ccs_pkg::burst_t      burst,
	output logic                 load_ok,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_char,
	output logic                 last_of_run
);

	logic [ccs_pkg::MAX_RESULTS-1:0][7:0] ch_q;
	logic [1:0]                           cnt_q;
	logic                                 pop;

	assign out_valid   = (cnt_q != 2'd0);
	assign pop         = out_valid && out_ready;
	assign load_ok     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign out_char    = ch_q[0];
	assign last_of_run = (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (burst_load) begin
			cnt_q <= burst.len;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (burst_load) begin
			ch_q <= burst.ch;
		end else if (pop) begin
			ch_q <= {ccs_pkg::CH_SPACE, ch_q[2], ch_q[1]};
		end
	end

	`ASSERT_AT(a_pop_counts_down, clk, arst_n,
		(pop && !burst_load) |=> (cnt_q == $past(cnt_q) - 2'd1),
		"burst count did not step down on a taken item")
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n,
		burst_load && cnt_q > 2'd1,
		"burst loaded over undelivered results")

endmodule

`default_nettype wire

/* design/c_comment_stripper.sv */
// Top level of the C comment stripper: input stage plus scan logic, then the burst register.
// Depends on ccs_pkg, ccs_core and ccs_burst_buf.
// Takes one source byte per item and gives the cleaned text one byte per item. An item is
// accepted every cycle while out_ready is high and each item yields at most one result; an item
// that yields k results (up to three, from flushing a held slash or backslash) holds the output
// burst register until all k are taken, and the next item waits until the burst is down to
// its last byte. Items that are only held (a slash or backslash) or a spliced newline give
// no result. An accepted item passes the input register, then the burst register.
`default_nettype none

module c_comment_stripper (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] text_char,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            last_of_run
);

	logic            load_ok;
	logic            burst_load;
	ccs_pkg::burst_t burst;

	ccs_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_char   (text_char),
		.end_of_text (end_of_text),
		.load_ok     (load_ok),
		.burst_load  (burst_load),
		.burst       (burst)
	);

	ccs_burst_buf u_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst_load  (burst_load),
		.burst       (burst),
		.load_ok     (load_ok),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

/* tb/c_comment_stripper_checker.sv */
// Checker for the C comment stripper: watches both channels, predicts the cleaned text
// per accepted item and compares every output item with the oldest prediction.
// Depends on ccs_pkg for the character codes and scan modes.
`default_nettype none

module c_comment_stripper_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] text_char,
	input  wire logic       end_of_text,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] out_char,
	input  wire logic       last_of_run,
	output int              mismatches,
	output int              bytes_waiting,
	output int              bytes_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} clean_byte_t;

	clean_byte_t clean_text_q[$];
	logic [7:0]  burst_q[$];

	logic [1:0] mode        = ccs_pkg::MODE_CODE;
	logic       slash_held  = 1'b0;
	logic       star_prev   = 1'b0;
	logic       bslash_held = 1'b0;

	int err_count  = 0;
	int n_checked  = 0;
	int n_waiting  = 0;

	assign mismatches    = err_count;
	assign bytes_waiting = n_waiting;
	assign bytes_checked = n_checked;

	// comment stage, one byte after line splicing
	task automatic scan_byte(input logic [7:0] x);
		case (mode)
			ccs_pkg::MODE_CODE: begin
				if (slash_held) begin
					slash_held = 1'b0;
					if (x == ccs_pkg::CH_SLASH) begin
						mode = ccs_pkg::MODE_LINE;
						burst_q.push_back(ccs_pkg::CH_SPACE);
						burst_q.push_back(ccs_pkg::CH_SPACE);
						return;
					end
					if (x == ccs_pkg::CH_STAR) begin
						mode = ccs_pkg::MODE_BLOCK;
						star_prev = 1'b0;
						burst_q.push_back(ccs_pkg::CH_SPACE);
						burst_q.push_back(ccs_pkg::CH_SPACE);
						return;
					end
					burst_q.push_back(ccs_pkg::CH_SLASH);
				end
				if (x == ccs_pkg::CH_SLASH) begin
					slash_held = 1'b1;
				end else begin
					if (x == ccs_pkg::CH_QUOTE)
						mode = ccs_pkg::MODE_STRING;
					burst_q.push_back(x);
				end
			end
			ccs_pkg::MODE_STRING: begin
				if (x == ccs_pkg::CH_QUOTE || x == ccs_pkg::CH_NEWLINE)
					mode = ccs_pkg::MODE_CODE;
				burst_q.push_back(x);
			end
			ccs_pkg::MODE_LINE: begin
				if (x == ccs_pkg::CH_NEWLINE) begin
					mode = ccs_pkg::MODE_CODE;
					burst_q.push_back(ccs_pkg::CH_NEWLINE);
				end else begin
					burst_q.push_back(ccs_pkg::CH_SPACE);
				end
			end
			default: begin
				if (star_prev && x == ccs_pkg::CH_SLASH) begin
					mode = ccs_pkg::MODE_CODE;
					star_prev = 1'b0;
					burst_q.push_back(ccs_pkg::CH_SPACE);
				end else begin
					star_prev = (x == ccs_pkg::CH_STAR);
					burst_q.push_back(x == ccs_pkg::CH_NEWLINE ?
						ccs_pkg::CH_NEWLINE : ccs_pkg::CH_SPACE);
				end
			end
		endcase
	endtask

	task automatic predict_item(input logic [7:0] x, input logic eot);
		burst_q.delete();
		if (eot) begin
			if (bslash_held) begin
				bslash_held = 1'b0;
				scan_byte(ccs_pkg::CH_BACKSLASH);
			end
			if (slash_held)
				burst_q.push_back(ccs_pkg::CH_SLASH);
			mode        = ccs_pkg::MODE_CODE;
			slash_held  = 1'b0;
			star_prev   = 1'b0;
			bslash_held = 1'b0;
		end else if (bslash_held) begin
			if (x == ccs_pkg::CH_NEWLINE) begin
				bslash_held = 1'b0;
			end else begin
				scan_byte(ccs_pkg::CH_BACKSLASH);
				if (x == ccs_pkg::CH_BACKSLASH) begin
					bslash_held = 1'b1;
				end else begin
					bslash_held = 1'b0;
					scan_byte(x);
				end
			end
		end else if (x == ccs_pkg::CH_BACKSLASH) begin
			bslash_held = 1'b1;
		end else begin
			scan_byte(x);
		end
		foreach (burst_q[i])
			clean_text_q.push_back('{ch: burst_q[i], last: (i == burst_q.size() - 1)});
	endtask

	always @(posedge clk) begin
		clean_byte_t exp_b;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (clean_text_q.size() == 0) begin
					$error("unexpected output item: out_char %02h last_of_run %0b",
						out_char, last_of_run);
					err_count++;
				end else begin
					exp_b = clean_text_q.pop_front();
					n_checked++;
					if (out_char !== exp_b.ch) begin
						$error("out_char: expected %02h, got %02h", exp_b.ch, out_char);
						err_count++;
					end
					if (last_of_run !== exp_b.last) begin
						$error("last_of_run: expected %0b, got %0b", exp_b.last, last_of_run);
						err_count++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_item(text_char, end_of_text);
		end
		n_waiting = clean_text_q.size();
	end

endmodule

`default_nettype wire

/* tb/c_comment_stripper_tb.sv */
// Testbench top for the C comment stripper: clock, reset, directed and random C text
// with random idling on both channels, and the verdict.
// Depends on ccs_pkg, c_comment_stripper and c_comment_stripper_checker.
`default_nettype none

module c_comment_stripper_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 500;
	localparam int CYCLE_LIMIT  = 200000;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic [7:0] text_char   = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_ready   = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_char;
	logic       last_of_run;

	int mismatches;
	int bytes_waiting;
	int bytes_checked;

	int items_sent  = 0;
	int eot_sent    = 0;
	int cycle_count = 0;
	bit calm        = 1'b0;

	always #5 clk = ~clk;

	c_comment_stripper u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.text_char   (text_char),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

	c_comment_stripper_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_char     (text_char),
		.end_of_text   (end_of_text),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_char      (out_char),
		.last_of_run   (last_of_run),
		.mismatches    (mismatches),
		.bytes_waiting (bytes_waiting),
		.bytes_checked (bytes_checked)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("c_comment_stripper_tb: FAIL");
			$finish;
		end
	end

	// entered and left at a falling edge
	task automatic send_char(input logic [7:0] c, input logic eot);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    = 1'b1;
		text_char   = c;
		end_of_text = eot;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (eot)
			eot_sent++;
		@(negedge clk);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	task automatic send_token();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			send_char(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
		else if (r < 38)
			send_char(ccs_pkg::CH_SLASH, 1'b0);
		else if (r < 44)
			send_char(ccs_pkg::CH_STAR, 1'b0);
		else if (r < 52)
			send_char(ccs_pkg::CH_QUOTE, 1'b0);
		else if (r < 58)
			send_char(ccs_pkg::CH_BACKSLASH, 1'b0);
		else if (r < 66)
			send_char(ccs_pkg::CH_NEWLINE, 1'b0);
		else if (r < 71)
			send_str("//");
		else if (r < 77)
			send_str("/*");
		else if (r < 83)
			send_str("*/");
		else if (r < 87)
			send_str("\\\n");
		else if (r < 97)
			send_char(8'($urandom_range(0, 255)), 1'b0);
		else
			send_char(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// receiver: random stall before each output item
	initial begin
		int stall;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		int random_start;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed
		send_str("/\\a");
		send_str("//\"x\n");
		send_str("/*/*/");
		send_str("\"/\\\n\"");
		send_str("\\\\x");
		send_char(ccs_pkg::CH_SLASH, 1'b0);
		send_char(8'h00, 1'b1);
		send_str("/*\"");
		send_char(8'hFF, 1'b1);

		// random, in phases with and without idling
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			repeat (20)
				send_token();
		end
		calm = 1'b0;
		in_valid = 1'b0;

		while (bytes_waiting != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("%0d input items sent (%0d end-of-text), %0d output items checked",
			items_sent, eot_sent, bytes_checked);
		$display("text mixed code, strings, line and block comments and line splices");
		if (mismatches == 0 && bytes_waiting == 0)
			$display("c_comment_stripper_tb: PASS");
		else
			$display("c_comment_stripper_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
